FILE: design/acm_pkg.sv
// Package for the arclength correspondence map: payload types, codes,
// controller states and controller/datapath command and status structs.
// No dependencies.
package acm_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_MAP_1_2 = 2'd1;
    localparam logic [1:0] OP_MAP_2_1 = 2'd2;

    localparam logic [1:0] REG_LENGTH_ONE  = 2'd0;
    localparam logic [1:0] REG_LENGTH_TWO  = 2'd1;
    localparam logic [1:0] REG_TOLERANCE   = 2'd2;
    localparam logic [1:0] REG_ENTRY_COUNT = 2'd3;

    localparam logic [15:0]      TOL_RESET   = 16'd410;
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(2);

    typedef struct packed {
        logic [1:0]        operation;
        logic [9:0]        entry_index;
        logic [31:0]       position_one;
        logic [31:0]       position_two;
        logic signed [31:0] query_position;
    } in_item_t;

    typedef struct packed {
        logic [31:0] mapped_position;
        logic        status;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SNAP, ST_WRAP_RD, ST_WRAP_CHK, ST_SRCH_RD, ST_SRCH_CMP,
        ST_END, ST_RD_EDGE, ST_RD_LO, ST_RD_HI, ST_PREP, ST_MUL, ST_DIV,
        ST_COMB, ST_REDUCE, ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        DP_NONE, DP_QUERY, DP_SNAP, DP_WRAP, DP_SCMP, DP_EDGE, DP_LO, DP_HI,
        DP_FLAT, DP_PREP, DP_MUL, DP_DIV, DP_COMB, DP_REDUCE, DP_OUT
    } dp_op_t;

    typedef enum logic [2:0] {
        A_ZERO, A_MID, A_LOM1, A_LO, A_NM1
    } addr_sel_t;

    typedef struct packed {
        dp_op_t    op;
        addr_sel_t addr_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic is_map12;
        logic oor;
        logic lo_lt_hi;
        logic lo_zero;
        logic lo_ge_n;
        logic span_bad;
        logic div_last;
    } dp_stat_t;

endpackage

FILE: design/arclength_correspondence_map_unit.sv
// Arclength correspondence map. Loads are taken while idle and give no item.
// A query takes k search steps, k <= ceil(log2(n+1)) for n entries, before its result
// shows; a query from curve two skips the wrap check. Edge, flat and out-of-range
// cases end sooner. The next item is taken once the result is loaded into the output
// register; a waiting result lets it in and stalls only the next result.
// Synchronous active-low reset clears control and config registers, not the tables.
module arclength_correspondence_map_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  acm_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output acm_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    acm_pkg::dp_cmd_t  cmd;
    acm_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    acm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid),
        .s_operation(s_data.operation), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .stat(stat), .cmd(cmd)
    );

    acm_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_valid(cfg_valid),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_accept(s_valid && s_ready), .s_data(s_data),
        .cmd(cmd), .stat(stat), .m_data(m_data)
    );

endmodule

FILE: design/acm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module acm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/acm_datapath.sv
// Datapath: config registers, breakpoint RAMs, snap, search pointers,
// interpolation with multiplier and restoring divider, result register.
// Depends on acm_pkg and acm_ram.
module acm_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              in_accept,
    input  acm_pkg::in_item_t s_data,
    input  acm_pkg::dp_cmd_t  cmd,
    output acm_pkg::dp_stat_t stat,
    output acm_pkg::out_item_t m_data
);

    localparam int AW = acm_pkg::ADDR_W;
    localparam int CW = acm_pkg::CNT_W;

    logic [30:0] len1_reg, len2_reg;
    logic [15:0] tol_reg;
    logic [CW-1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len1_reg <= '0;
            len2_reg <= '0;
            tol_reg  <= acm_pkg::TOL_RESET;
            cnt_reg  <= acm_pkg::COUNT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                acm_pkg::REG_LENGTH_ONE:  len1_reg <= cfg_data[30:0];
                acm_pkg::REG_LENGTH_TWO:  len2_reg <= cfg_data[30:0];
                acm_pkg::REG_TOLERANCE:   tol_reg  <= cfg_data[15:0];
                acm_pkg::REG_ENTRY_COUNT: cnt_reg  <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // entry count saturated to [2, depth]
    logic [CW-1:0] n;
    always_comb begin
        if (cnt_reg < CW'(2)) n = CW'(2);
        else if (cnt_reg > CW'(acm_pkg::TABLE_DEPTH)) n = CW'(acm_pkg::TABLE_DEPTH);
        else n = cnt_reg;
    end

    logic        map12_reg;
    logic signed [31:0] q_reg;
    logic [31:0] s_reg;
    logic        oor_reg;
    logic [CW-1:0] lo_reg, hi_reg;
    logic [31:0] a_lo_reg, a_hi_reg, b_lo_reg, b_hi_reg;
    logic [31:0] dif_reg, mag_reg, span_reg;
    logic        neg_reg;
    logic [31:0] rem_reg, quo_reg;
    logic [acm_pkg::DIV_CNT_W-1:0] dcnt_reg;
    logic [31:0] res_reg;
    logic        rstat_reg;
    acm_pkg::out_item_t out_reg;

    // RAMs
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd1, rd2, a_data, b_data;
    logic          wr_en;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;

    assign wr_en   = in_accept && (s_data.operation == acm_pkg::OP_LOAD);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CW:1];

    always_comb begin
        case (cmd.addr_sel)
            acm_pkg::A_ZERO: rd_addr = '0;
            acm_pkg::A_MID:  rd_addr = mid[AW-1:0];
            acm_pkg::A_LOM1: rd_addr = AW'(lo_reg - CW'(1));
            acm_pkg::A_LO:   rd_addr = lo_reg[AW-1:0];
            acm_pkg::A_NM1:  rd_addr = AW'(n - CW'(1));
            default:         rd_addr = '0;
        endcase
    end

    acm_ram #(.WIDTH(32), .DEPTH(acm_pkg::TABLE_DEPTH)) u_ram_one (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(s_data.entry_index[AW-1:0]),
        .wr_data(s_data.position_one), .rd_addr(rd_addr), .rd_data(rd1)
    );
    acm_ram #(.WIDTH(32), .DEPTH(acm_pkg::TABLE_DEPTH)) u_ram_two (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(s_data.entry_index[AW-1:0]),
        .wr_data(s_data.position_two), .rd_addr(rd_addr), .rd_data(rd2)
    );

    assign a_data = map12_reg ? rd1 : rd2;
    assign b_data = map12_reg ? rd2 : rd1;

    // snap
    logic [30:0] len;
    logic signed [33:0] qe, le, te, aq, dq, ad;
    always_comb begin
        len = map12_reg ? len1_reg : len2_reg;
        qe  = 34'(q_reg);
        le  = {3'b000, len};
        te  = {18'd0, tol_reg};
        aq  = (qe < 0) ? -qe : qe;
        dq  = qe - le;
        ad  = (dq < 0) ? -dq : dq;
    end

    // interpolation setup
    logic [31:0] span_c, dif_c;
    always_comb begin
        span_c = a_hi_reg - a_lo_reg;
        dif_c  = (s_reg > a_lo_reg) ? s_reg - a_lo_reg : 32'd0;
        if (dif_c > span_c) dif_c = span_c;
    end

    logic [63:0] prod;
    logic [32:0] trial;
    assign prod  = 64'(dif_reg) * 64'(mag_reg);
    assign trial = {rem_reg, quo_reg[31]};

    always_ff @(posedge aclk) begin
        case (cmd.op)
            acm_pkg::DP_QUERY: begin
                map12_reg <= (s_data.operation == acm_pkg::OP_MAP_1_2);
                q_reg     <= s_data.query_position;
            end
            acm_pkg::DP_SNAP: begin
                oor_reg   <= 1'b0;
                rstat_reg <= 1'b0;
                lo_reg    <= '0;
                hi_reg    <= n;
                if (aq < te) begin
                    s_reg <= '0;
                end else if (ad < te) begin
                    s_reg <= {1'b0, len};
                end else if (qe < 0 || qe > le) begin
                    oor_reg   <= 1'b1;
                    rstat_reg <= 1'b1;
                    res_reg   <= '0;
                end else begin
                    s_reg <= q_reg[31:0];
                end
            end
            acm_pkg::DP_WRAP: begin
                if (s_reg < rd1) s_reg <= s_reg + {1'b0, len1_reg};
            end
            acm_pkg::DP_SCMP: begin
                if (a_data < s_reg) lo_reg <= mid + CW'(1);
                else hi_reg <= mid;
            end
            acm_pkg::DP_EDGE: res_reg <= b_data;
            acm_pkg::DP_LO: begin
                a_lo_reg <= a_data;
                b_lo_reg <= b_data;
            end
            acm_pkg::DP_HI: begin
                a_hi_reg <= a_data;
                b_hi_reg <= b_data;
            end
            acm_pkg::DP_FLAT: res_reg <= b_lo_reg;
            acm_pkg::DP_PREP: begin
                span_reg <= span_c;
                dif_reg  <= dif_c;
                neg_reg  <= (b_hi_reg < b_lo_reg);
                mag_reg  <= (b_hi_reg < b_lo_reg) ? b_lo_reg - b_hi_reg
                                                  : b_hi_reg - b_lo_reg;
            end
            acm_pkg::DP_MUL: begin
                // high half is below span, so the quotient fits 32 bits
                rem_reg  <= prod[63:32];
                quo_reg  <= prod[31:0];
                dcnt_reg <= '0;
            end
            acm_pkg::DP_DIV: begin
                if (trial >= {1'b0, span_reg}) begin
                    rem_reg <= 32'(trial - {1'b0, span_reg});
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end else begin
                    rem_reg <= trial[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            acm_pkg::DP_COMB: res_reg <= neg_reg ? b_lo_reg - quo_reg : b_lo_reg + quo_reg;
            acm_pkg::DP_REDUCE: begin
                if (!map12_reg && len1_reg != '0 && res_reg >= {1'b0, len1_reg})
                    res_reg <= res_reg - {1'b0, len1_reg};
            end
            acm_pkg::DP_OUT: begin
                out_reg.mapped_position <= res_reg;
                out_reg.status          <= rstat_reg;
            end
            default: ;
        endcase
    end

    assign stat.is_map12 = map12_reg;
    assign stat.oor      = oor_reg;
    assign stat.lo_lt_hi = (lo_reg < hi_reg);
    assign stat.lo_zero  = (lo_reg == '0);
    assign stat.lo_ge_n  = (lo_reg >= n);
    assign stat.span_bad = (a_hi_reg <= a_lo_reg);
    assign stat.div_last = (dcnt_reg == acm_pkg::DIV_CNT_W'(acm_pkg::DIV_STEPS - 1));
    assign m_data        = out_reg;

endmodule

FILE: design/acm_ctrl.sv
// Controller state machine: sequences snap, wrap check, search, fetch, multiply,
// divide, reduce and output; owns the handshake flags.
// Depends on acm_pkg.
module acm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic [1:0]        s_operation,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  acm_pkg::dp_stat_t stat,
    output acm_pkg::dp_cmd_t  cmd
);

    acm_pkg::state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= acm_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        logic out_load;
        out_load     = 1'b0;
        state_next   = state_reg;
        cmd.op       = acm_pkg::DP_NONE;
        cmd.addr_sel = acm_pkg::A_ZERO;
        s_ready      = 1'b0;
        case (state_reg)
            acm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && (s_operation == acm_pkg::OP_MAP_1_2 ||
                                s_operation == acm_pkg::OP_MAP_2_1)) begin
                    cmd.op     = acm_pkg::DP_QUERY;
                    state_next = acm_pkg::ST_SNAP;
                end
            end
            acm_pkg::ST_SNAP: begin
                cmd.op     = acm_pkg::DP_SNAP;
                state_next = acm_pkg::ST_WRAP_RD;
            end
            acm_pkg::ST_WRAP_RD: begin
                cmd.addr_sel = acm_pkg::A_ZERO;
                if (stat.oor) state_next = acm_pkg::ST_REDUCE;
                else if (stat.is_map12) state_next = acm_pkg::ST_WRAP_CHK;
                else state_next = acm_pkg::ST_SRCH_RD;
            end
            acm_pkg::ST_WRAP_CHK: begin
                cmd.op     = acm_pkg::DP_WRAP;
                state_next = acm_pkg::ST_SRCH_RD;
            end
            acm_pkg::ST_SRCH_RD: begin
                cmd.addr_sel = acm_pkg::A_MID;
                state_next   = stat.lo_lt_hi ? acm_pkg::ST_SRCH_CMP : acm_pkg::ST_END;
            end
            acm_pkg::ST_SRCH_CMP: begin
                cmd.op     = acm_pkg::DP_SCMP;
                state_next = acm_pkg::ST_SRCH_RD;
            end
            acm_pkg::ST_END: begin
                if (stat.lo_zero) begin
                    cmd.addr_sel = acm_pkg::A_ZERO;
                    state_next   = acm_pkg::ST_RD_EDGE;
                end else if (stat.lo_ge_n) begin
                    cmd.addr_sel = acm_pkg::A_NM1;
                    state_next   = acm_pkg::ST_RD_EDGE;
                end else begin
                    cmd.addr_sel = acm_pkg::A_LOM1;
                    state_next   = acm_pkg::ST_RD_LO;
                end
            end
            acm_pkg::ST_RD_EDGE: begin
                cmd.op     = acm_pkg::DP_EDGE;
                state_next = acm_pkg::ST_REDUCE;
            end
            acm_pkg::ST_RD_LO: begin
                cmd.op       = acm_pkg::DP_LO;
                cmd.addr_sel = acm_pkg::A_LO;
                state_next   = acm_pkg::ST_RD_HI;
            end
            acm_pkg::ST_RD_HI: begin
                cmd.op     = acm_pkg::DP_HI;
                state_next = acm_pkg::ST_PREP;
            end
            acm_pkg::ST_PREP: begin
                if (stat.span_bad) begin
                    cmd.op     = acm_pkg::DP_FLAT;
                    state_next = acm_pkg::ST_REDUCE;
                end else begin
                    cmd.op     = acm_pkg::DP_PREP;
                    state_next = acm_pkg::ST_MUL;
                end
            end
            acm_pkg::ST_MUL: begin
                cmd.op     = acm_pkg::DP_MUL;
                state_next = acm_pkg::ST_DIV;
            end
            acm_pkg::ST_DIV: begin
                cmd.op = acm_pkg::DP_DIV;
                if (stat.div_last) state_next = acm_pkg::ST_COMB;
            end
            acm_pkg::ST_COMB: begin
                cmd.op     = acm_pkg::DP_COMB;
                state_next = acm_pkg::ST_REDUCE;
            end
            acm_pkg::ST_REDUCE: begin
                cmd.op     = acm_pkg::DP_REDUCE;
                state_next = acm_pkg::ST_OUT;
            end
            acm_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op     = acm_pkg::DP_OUT;
                    out_load   = 1'b1;
                    state_next = acm_pkg::ST_IDLE;
                end
            end
            default: state_next = acm_pkg::ST_IDLE;
        endcase
        if (out_load) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
        else m_valid_next = m_valid_reg;
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: design/acm_checker.sv
// Port-level checks for the correspondence map, bound to the top level.
// Depends on acm_pkg.
module acm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input acm_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input acm_pkg::out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item dropped or changed while stalled");

    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status |-> m_data.mapped_position == 32'd0)
        else $error("out-of-range item with nonzero position");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.operation == acm_pkg::OP_MAP_1_2 ||
        s_data.operation == acm_pkg::OP_MAP_2_1) |=> !s_ready)
        else $error("new item taken while a query is in work");

endmodule

bind arclength_correspondence_map_unit acm_checker u_acm_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

FILE: tb/tb_arclength_correspondence_map_unit.sv
// Testbench for arclength_correspondence_map_unit: breakpoint loads and queries
// checked against a local predictor of the block. Depends on acm_pkg.
`timescale 1ns / 100ps

module tb_arclength_correspondence_map_unit;

    localparam int PAUSE_CYCLES = 80;

    typedef struct {
        acm_pkg::in_item_t  item;
        bit                 typed;
        acm_pkg::out_item_t want;
    } row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    acm_pkg::in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    acm_pkg::out_item_t m_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0]  cfg_index = acm_pkg::REG_LENGTH_ONE;
    logic [31:0] cfg_data = '0;

    // predictor state
    logic [31:0] curve_one_tbl [acm_pkg::TABLE_DEPTH];
    logic [31:0] curve_two_tbl [acm_pkg::TABLE_DEPTH];
    logic [30:0] len_one, len_two;
    logic [15:0] snap_tol;
    logic [10:0] pair_count;

    acm_pkg::out_item_t pending_maps[$];
    row_t      dir_rows[$];
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    arclength_correspondence_map_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic int live_pairs();
        if (pair_count < 2) return 2;
        if (pair_count > acm_pkg::TABLE_DEPTH) return acm_pkg::TABLE_DEPTH;
        return pair_count;
    endfunction

    // lower-bound search on one table, linear interpolation onto the other
    function automatic logic [31:0] interpolate(bit from_one, logic [63:0] s);
        int n, lo, hi, mid;
        logic [63:0] a_lo, a_hi, dif, span, mag, quo;
        logic [31:0] b_lo, b_hi;
        n = live_pairs();
        lo = 0;
        hi = n;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if ({32'd0, from_one ? curve_one_tbl[mid] : curve_two_tbl[mid]} < s) lo = mid + 1;
            else hi = mid;
        end
        if (lo == 0) return from_one ? curve_two_tbl[0] : curve_one_tbl[0];
        if (lo >= n) return from_one ? curve_two_tbl[n-1] : curve_one_tbl[n-1];
        a_lo = from_one ? curve_one_tbl[lo-1] : curve_two_tbl[lo-1];
        a_hi = from_one ? curve_one_tbl[lo] : curve_two_tbl[lo];
        b_lo = from_one ? curve_two_tbl[lo-1] : curve_one_tbl[lo-1];
        b_hi = from_one ? curve_two_tbl[lo] : curve_one_tbl[lo];
        if (a_hi <= a_lo) return b_lo;
        span = a_hi - a_lo;
        dif = (s > a_lo) ? s - a_lo : 64'd0;
        if (dif > span) dif = span;
        if (b_hi >= b_lo) begin
            mag = {32'd0, b_hi - b_lo};
            quo = (dif * mag) / span;
            return b_lo + quo[31:0];
        end
        mag = {32'd0, b_lo - b_hi};
        quo = (dif * mag) / span;
        return b_lo - quo[31:0];
    endfunction

    // returns 1 when the item produces a result
    function automatic bit predict_map(acm_pkg::in_item_t it, output acm_pkg::out_item_t res);
        longint q, len, mag_q, gap_q;
        logic [63:0] s;
        logic [31:0] r;
        res = '0;
        if (it.operation == acm_pkg::OP_LOAD) begin
            curve_one_tbl[it.entry_index] = it.position_one;
            curve_two_tbl[it.entry_index] = it.position_two;
            return 0;
        end
        if (it.operation != acm_pkg::OP_MAP_1_2 && it.operation != acm_pkg::OP_MAP_2_1)
            return 0;
        q = it.query_position;
        len = (it.operation == acm_pkg::OP_MAP_1_2) ? len_one : len_two;
        mag_q = q < 0 ? -q : q;
        gap_q = q - len;
        if (gap_q < 0) gap_q = -gap_q;
        if (mag_q < snap_tol) s = 0;
        else if (gap_q < snap_tol) s = len;
        else if (q < 0 || q > len) begin
            res.status = 1'b1;
            return 1;
        end else s = q;
        if (it.operation == acm_pkg::OP_MAP_1_2) begin
            if (s < {32'd0, curve_one_tbl[0]}) s = s + len_one;
            r = interpolate(1'b1, s);
        end else begin
            r = interpolate(1'b0, s);
            if (len_one != 0 && r >= len_one) r = r - len_one;
        end
        res.mapped_position = r;
        return 1;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        acm_pkg::out_item_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_maps.size() == 0) begin
                report_mismatch($sformatf("unexpected item pos=%h st=%0d",
                                          m_data.mapped_position, m_data.status));
            end else begin
                exp_r = pending_maps.pop_front();
                if (m_data.mapped_position !== exp_r.mapped_position)
                    report_mismatch($sformatf("mapped_position %h, want %h",
                                              m_data.mapped_position, exp_r.mapped_position));
                if (m_data.status !== exp_r.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              m_data.status, exp_r.status));
            end
        end
    end

    task automatic send_item(acm_pkg::in_item_t it, bit typed = 0,
                             acm_pkg::out_item_t want = '0);
        acm_pkg::out_item_t res;
        bit has_res;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        has_res = predict_map(it, res);
        if (typed) pending_maps = {pending_maps, want};
        else if (has_res) pending_maps = {pending_maps, res};
    endtask

    // wait out every result, then the block's own latency
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_maps.size() != 0) @(posedge aclk);
        repeat (PAUSE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            acm_pkg::REG_LENGTH_ONE:  len_one = val[30:0];
            acm_pkg::REG_LENGTH_TWO:  len_two = val[30:0];
            acm_pkg::REG_TOLERANCE:   snap_tol = val[15:0];
            acm_pkg::REG_ENTRY_COUNT: pair_count = val[10:0];
            default: ;
        endcase
    endtask

    task automatic add_row(logic [1:0] op, logic [9:0] idx, logic [31:0] p1, logic [31:0] p2,
                           logic [31:0] q, bit typed = 0, logic [31:0] pos = 0, bit st = 0);
        row_t r;
        r.item = '{operation: op, entry_index: idx, position_one: p1,
                   position_two: p2, query_position: q};
        r.typed = typed;
        r.want = '{mapped_position: pos, status: st};
        dir_rows = {dir_rows, r};
    endtask

    task automatic run_rows();
        foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        dir_rows.delete();
        drain();
    endtask

    // monotone-ish table with some flat spans and stray values
    task automatic fill_tables(int n, longint l1, longint l2, bit desc);
        longint va, vb, step_a, step_b;
        acm_pkg::in_item_t it;
        step_a = (l1 + l1 / 4) / n + 1;
        step_b = (l2 + l2 / 4) / n + 1;
        va = $urandom_range(0, step_a);
        vb = desc ? l2 + $urandom_range(0, step_b) : $urandom_range(0, step_b);
        for (int i = 0; i < n; i++) begin
            it = '0;
            it.operation = acm_pkg::OP_LOAD;
            it.entry_index = 10'(i);
            it.position_one = ($urandom_range(99) < 5) ? $urandom : va[31:0];
            it.position_two = vb[31:0];
            send_item(it);
            if ($urandom_range(99) >= 10) va += $urandom_range(1, 2 * step_a);
            vb = desc ? vb - $urandom_range(0, 2 * step_b) : vb + $urandom_range(0, 2 * step_b);
        end
    endtask

    task automatic random_items(int count, int n);
        acm_pkg::in_item_t it;
        longint l, q;
        int pick;
        for (int k = 0; k < count; k++) begin
            it = '0;
            pick = $urandom_range(99);
            if (pick < 8) begin
                it.operation = acm_pkg::OP_LOAD;
                it.entry_index = 10'($urandom_range(0, n - 1));
                it.position_one = $urandom;
                it.position_two = $urandom;
            end else if (pick < 12) begin
                it.operation = acm_pkg::OP_LOAD;
                it.entry_index = 10'($urandom);
                it.position_one = $urandom;
                it.position_two = $urandom;
            end else if (pick < 15) begin
                it.operation = 2'd3;
                it.query_position = $urandom;
            end else begin
                it.operation = $urandom_range(0, 1) ? acm_pkg::OP_MAP_1_2 : acm_pkg::OP_MAP_2_1;
                l = (it.operation == acm_pkg::OP_MAP_1_2) ? len_one : len_two;
                pick = $urandom_range(99);
                if (pick < 60) q = -2 * longint'(snap_tol) + $urandom_range(0, l + 4 * snap_tol);
                else if (pick < 75) q = $urandom_range(0, 2 * snap_tol + 4) - snap_tol - 2;
                else if (pick < 90) q = l + $urandom_range(0, 2 * snap_tol + 4) - snap_tol - 2;
                else q = $urandom;
                it.query_position = q[31:0];
            end
            send_item(it);
        end
    endtask

    initial begin
        #50_000_000;
        $display("arclength_correspondence_map_unit verification failed");
        $finish;
    end

    initial begin
        int n;
        longint l1, l2;
        len_one = 0;
        len_two = 0;
        snap_tol = acm_pkg::TOL_RESET;
        pair_count = acm_pkg::COUNT_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults after reset: both lengths zero
        add_row(acm_pkg::OP_MAP_1_2, 0, 0, 0, 5000, 1, 0, 1);
        add_row(acm_pkg::OP_MAP_2_1, 0, 0, 0, -5000, 1, 0, 1);
        add_row(2'd3, 0, 0, 0, 0);
        add_row(acm_pkg::OP_LOAD, 0, 0, 0, 0);
        add_row(acm_pkg::OP_LOAD, 1, 4096, 8192, 0);
        add_row(acm_pkg::OP_MAP_1_2, 0, 0, 0, 100, 1, 0, 0);
        add_row(acm_pkg::OP_MAP_2_1, 0, 0, 0, -409, 1, 0, 0);
        add_row(acm_pkg::OP_MAP_1_2, 0, 0, 0, 32'h8000_0000, 1, 0, 1);
        add_row(acm_pkg::OP_MAP_1_2, 0, 0, 0, 32'h7fff_ffff, 1, 0, 1);
        run_rows();

        write_reg(acm_pkg::REG_LENGTH_ONE, 32'h7fff_ffff);
        write_reg(acm_pkg::REG_LENGTH_TWO, 32'h7fff_ffff);
        write_reg(acm_pkg::REG_TOLERANCE, 32'hffff);
        write_reg(acm_pkg::REG_ENTRY_COUNT, 3);
        add_row(acm_pkg::OP_LOAD, 0, 32'h0001_0000, 32'hffff_ffff, 0);
        add_row(acm_pkg::OP_LOAD, 1, 32'h4000_0000, 32'h0000_1000, 0);
        add_row(acm_pkg::OP_LOAD, 2, 32'hffff_ffff, 32'h8000_0000, 0);
        add_row(acm_pkg::OP_LOAD, 1023, 32'hffff_ffff, 32'hffff_ffff, 0);
        add_row(acm_pkg::OP_MAP_1_2, 0, 0, 0, 32'h7fff_ffff);
        add_row(acm_pkg::OP_MAP_1_2, 0, 0, 0, 32'h7ffe_0002);
        add_row(acm_pkg::OP_MAP_1_2, 0, 0, 0, 32'h8000_0000);
        add_row(acm_pkg::OP_MAP_1_2, 0, 0, 0, -65534);
        add_row(acm_pkg::OP_MAP_1_2, 0, 0, 0, 65535);
        add_row(acm_pkg::OP_MAP_1_2, 0, 0, 0, 32'h2000_0000);
        add_row(acm_pkg::OP_MAP_2_1, 0, 0, 0, 32'h0000_1000);
        add_row(acm_pkg::OP_MAP_2_1, 0, 0, 0, 32'h6000_0000);
        add_row(acm_pkg::OP_MAP_2_1, 0, 0, 0, 32'h7fff_0000);
        add_row(2'd3, 10'h3ff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        run_rows();

        for (int p = 0; p < 9; p++) begin
            case (p)
                0: begin send_idle_pct = 18; recv_idle_pct = 55; end
                3: begin send_idle_pct = 55; recv_idle_pct = 18; end
                6: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                default: ;
            endcase
            case (p)
                0: begin l1 = 40960; l2 = 81920; write_reg(acm_pkg::REG_TOLERANCE, 410);
                         write_reg(acm_pkg::REG_ENTRY_COUNT, 4); end
                1: begin l1 = 32'h7fff_ffff; l2 = 32'h7fff_ffff;
                         write_reg(acm_pkg::REG_TOLERANCE, 32'hffff);
                         write_reg(acm_pkg::REG_ENTRY_COUNT, 1); end
                2: begin l1 = 0; l2 = 12345678; write_reg(acm_pkg::REG_TOLERANCE, 0);
                         write_reg(acm_pkg::REG_ENTRY_COUNT, 0); end
                5: begin l1 = $urandom_range(1, 32'h7fff_ffff);
                         l2 = $urandom_range(1, 32'h7fff_ffff);
                         write_reg(acm_pkg::REG_TOLERANCE, $urandom_range(0, 4096));
                         write_reg(acm_pkg::REG_ENTRY_COUNT, 2047); end
                default: begin
                    l1 = $urandom_range(0, 32'h7fff_ffff);
                    l2 = $urandom_range(0, 32'h7fff_ffff);
                    write_reg(acm_pkg::REG_TOLERANCE, $urandom_range(0, 65535));
                    write_reg(acm_pkg::REG_ENTRY_COUNT, $urandom_range(2, 16));
                end
            endcase
            write_reg(acm_pkg::REG_LENGTH_ONE, l1[31:0]);
            write_reg(acm_pkg::REG_LENGTH_TWO, l2[31:0]);
            n = live_pairs();
            fill_tables(n, l1, l2, $urandom_range(0, 3) == 0);
            random_items(6, n);
            if (p == 4) drain();
            random_items(6, n);
            drain();
        end

        repeat (PAUSE_CYCLES) @(posedge aclk);
        if (mismatches == 0) $display("arclength_correspondence_map_unit verification clean");
        else $display("arclength_correspondence_map_unit verification failed");
        $finish;
    end

endmodule

FILE: files.f
design/acm_pkg.sv
design/acm_ram.sv
design/acm_datapath.sv
design/acm_ctrl.sv
design/arclength_correspondence_map_unit.sv
design/acm_checker.sv
tb/tb_arclength_correspondence_map_unit.sv
